// ----- sv/sctd_pkg.sv -----
// ----------------------------------------------------------------------------
// sctd_pkg
// Field widths, reciprocal constants, month table and the hand-off struct
// that are shared by the seconds-to-calendar-date pipeline.
// ----------------------------------------------------------------------------
package sctd_pkg;

  localparam int EpochW    = 32;
  localparam int SecW      = 6;
  localparam int HourW     = 5;
  localparam int MdayW     = 5;
  localparam int MonW      = 4;
  localparam int YearW     = 12;
  localparam int YdayW     = 9;
  localparam int WdayW     = 3;
  localparam int TotMinW   = 27;
  localparam int TotHrW    = 21;
  localparam int DayCntW   = 16;
  localparam int QuadW     = 6;
  localparam int InQuadW   = 11;
  localparam int YrsW      = 8;
  localparam int NumMonths = 12;

  localparam int SecsPerMin   = 60;
  localparam int MinsPerHour  = 60;
  localparam int HoursPerDay  = 24;
  localparam int DaysPerWeek  = 7;
  localparam int WeekdayBase  = 4;

  // floor(x / d) == (x * Recip) >> Shift over the operand range used
  localparam logic [30:0] RecipMin  = 31'd1145324613;  // /15 on secs >> 2
  localparam logic [25:0] RecipHour = 26'd35791395;    // /15 on tot_min >> 2
  localparam logic [18:0] RecipDay  = 19'd349526;      // /3 on tot_hr >> 3
  localparam logic [16:0] RecipWeek = 17'd74899;       // /7
  localparam logic [16:0] RecipQuad = 17'd91868;       // /1461
  localparam logic [16:0] RecipYear = 17'd91930;      // /365

  localparam logic [DayCntW-1:0] DaysTo1970  = 16'd731;
  localparam logic [InQuadW-1:0] DaysPerQuad = 11'd1461;
  localparam logic [InQuadW-1:0] FebEndLeap  = 11'd60;
  localparam logic [InQuadW-1:0] LeapYearEnd = 11'd365;
  localparam logic [YdayW-1:0]   YearDays    = 9'd365;
  localparam logic [YearW-1:0]   BaseYear    = 12'd1968;

  typedef logic [YdayW-1:0] month_table_t [NumMonths];
  localparam month_table_t MonthStart = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [SecW-1:0]    sec;
    logic [SecW-1:0]    min;
    logic [HourW-1:0]   hour;
    logic [DayCntW-1:0] tot_day;
  } tod_t;

endpackage

// ----- sv/sctd_if.sv -----
// ----------------------------------------------------------------------------
// sctd_in_if / sctd_out_if
// Valid/ready channels carrying a timestamp in and a calendar date out.
// ----------------------------------------------------------------------------
interface sctd_in_if;
  logic                         valid;
  logic                         ready;
  logic [sctd_pkg::EpochW-1:0]  epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface sctd_out_if;
  logic                        valid;
  logic                        ready;
  logic [sctd_pkg::SecW-1:0]   sec_of_minute;
  logic [sctd_pkg::SecW-1:0]   min_of_hour;
  logic [sctd_pkg::HourW-1:0]  hour_of_day;
  logic [sctd_pkg::MdayW-1:0]  day_of_month;
  logic [sctd_pkg::MonW-1:0]   month_number;
  logic [sctd_pkg::YearW-1:0]  full_year;
  logic [sctd_pkg::YdayW-1:0]  day_of_year;
  logic [sctd_pkg::WdayW-1:0]  weekday;

  modport source (output valid, output sec_of_minute, output min_of_hour,
                  output hour_of_day, output day_of_month, output month_number,
                  output full_year, output day_of_year, output weekday,
                  input ready);
  modport sink (input valid, input sec_of_minute, input min_of_hour,
                input hour_of_day, input day_of_month, input month_number,
                input full_year, input day_of_year, input weekday,
                output ready);
endinterface

// ----- sv/sctd_clock_stages.sv -----
// ----------------------------------------------------------------------------
// sctd_clock_stages
// Four-stage split of a seconds count into second, minute, hour and a
// whole-day count, using registered reciprocal multiplies.
// ----------------------------------------------------------------------------
module sctd_clock_stages (
  input  logic            clk,
  input  logic            rst,
  sctd_in_if.sink         stamp,
  output logic            day_valid,
  input  logic            day_ready,
  output sctd_pkg::tod_t  day_item
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic [sctd_pkg::SecW-1:0]    sec_lo_1;
  logic [sctd_pkg::TotMinW-1:0] tot_min_1;
  logic [sctd_pkg::SecW-1:0]    sec_2;
  logic [sctd_pkg::SecW-1:0]    min_lo_2;
  logic [sctd_pkg::TotHrW-1:0]  tot_hr_2;
  logic [sctd_pkg::SecW-1:0]    sec_3;
  logic [sctd_pkg::SecW-1:0]    min_3;
  logic [sctd_pkg::HourW-1:0]   hr_lo_3;
  logic [sctd_pkg::DayCntW-1:0] tot_day_3;
  sctd_pkg::tod_t               item_4;

  logic [60:0] min_prod;
  logic [50:0] hr_prod;
  logic [36:0] day_prod;

  assign en4 = !v4 || day_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign stamp.ready = en1;
  assign day_valid   = v4;
  assign day_item    = item_4;

  assign min_prod = stamp.epoch_seconds[31:2] * sctd_pkg::RecipMin;
  assign hr_prod  = tot_min_1[26:2] * sctd_pkg::RecipHour;
  assign day_prod = tot_hr_2[20:3] * sctd_pkg::RecipDay;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= stamp.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sec_lo_1  <= stamp.epoch_seconds[5:0];
      tot_min_1 <= min_prod[60:34];
    end
    if (en2) begin
      sec_2    <= sec_lo_1 - sctd_pkg::SecW'(tot_min_1 *
                  sctd_pkg::TotMinW'(sctd_pkg::SecsPerMin));
      min_lo_2 <= tot_min_1[5:0];
      tot_hr_2 <= hr_prod[49:29];
    end
    if (en3) begin
      sec_3     <= sec_2;
      min_3     <= min_lo_2 - sctd_pkg::SecW'(tot_hr_2 *
                   sctd_pkg::TotHrW'(sctd_pkg::MinsPerHour));
      hr_lo_3   <= tot_hr_2[4:0];
      tot_day_3 <= day_prod[35:20];
    end
    if (en4) begin
      item_4.sec     <= sec_3;
      item_4.min     <= min_3;
      item_4.hour    <= hr_lo_3 - sctd_pkg::HourW'(tot_day_3 *
                        sctd_pkg::DayCntW'(sctd_pkg::HoursPerDay));
      item_4.tot_day <= tot_day_3;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    v4 && !day_ready |=> v4)
    else $error("day item dropped while stalled");

  a_item_stable: assert property (@(posedge clk) disable iff (rst)
    v4 && !day_ready |=> $stable(item_4))
    else $error("day item changed while stalled");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (item_4.sec < 6'd60) && (item_4.min < 6'd60) && (item_4.hour < 5'd24))
    else $error("time of day out of range");

endmodule

// ----- sv/seconds_to_calendar_date_unit.sv -----
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_unit
// Converts a count of seconds since 1970-01-01 00:00:00 into time of day,
// day of month, month, year, day of year and weekday.
//
// Channels: stamp carries epoch_seconds in; date carries the broken-down
// date out. Both move an item at a clock edge with valid and ready high.
// Leap years are every fourth year counted from 1968, so 2100 is a leap year.
//
// Throughput: one item per cycle while the date receiver is ready. The
// conversion runs through a chain of reciprocal multiplies for /60, /60,
// /24, /7, /1461 and /365, each product registered before its next step.
//
// Reset clears every stage's valid bit; no item is in flight afterward.
// When date.ready is low, the item at the output holds and upstream stages
// keep filling empty slots; stamp.ready drops only when every stage is full.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date_unit (
  input  logic        clk,
  input  logic        rst,
  sctd_in_if.sink     stamp,
  sctd_out_if.source  date
);

  logic           day_valid;
  logic           day_ready;
  sctd_pkg::tod_t day_item;

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  // stage 1
  logic [sctd_pkg::DayCntW-1:0] days68_c;
  logic [sctd_pkg::DayCntW-1:0] wsum_c;
  logic [32:0]                  wk_prod;
  logic [32:0]                  quad_prod;
  logic [sctd_pkg::DayCntW-1:0] days68_1;
  logic [2:0]                   wsum_lo_1;
  logic [2:0]                   q7_lo_1;
  logic [sctd_pkg::QuadW-1:0]   quads_1;
  sctd_pkg::tod_t               tod_1;

  // stage 2
  logic [sctd_pkg::InQuadW-1:0] in_quad_c;
  logic                         past_feb_c;
  logic [sctd_pkg::DayCntW-1:0] diff_2;
  logic                         inc_2;
  logic [sctd_pkg::WdayW-1:0]   wday_2;
  sctd_pkg::tod_t               tod_2;

  // stage 3
  logic [32:0]                  yr_prod;
  logic [sctd_pkg::YrsW-1:0]    yrs_3;
  logic [sctd_pkg::YdayW-1:0]   diff_lo_3;
  logic                         inc_3;
  logic [sctd_pkg::WdayW-1:0]   wday_3;
  sctd_pkg::tod_t               tod_3;

  // stage 4
  logic [sctd_pkg::YdayW-1:0]   yday_4;
  logic                         leap_4;
  logic [sctd_pkg::YearW-1:0]   year_4;
  logic [sctd_pkg::WdayW-1:0]   wday_4;
  sctd_pkg::tod_t               tod_4;

  // stage 5 (output)
  logic [sctd_pkg::MonW-1:0]    mon_c;
  logic [sctd_pkg::YdayW-1:0]   st_c;
  logic [sctd_pkg::YdayW-1:0]   cand;
  logic [sctd_pkg::SecW-1:0]    sec_5;
  logic [sctd_pkg::SecW-1:0]    min_5;
  logic [sctd_pkg::HourW-1:0]   hour_5;
  logic [sctd_pkg::MdayW-1:0]   mday_5;
  logic [sctd_pkg::MonW-1:0]    mon_5;
  logic [sctd_pkg::YearW-1:0]   year_5;
  logic [sctd_pkg::YdayW-1:0]   yday_5;
  logic [sctd_pkg::WdayW-1:0]   wday_5;

  sctd_clock_stages u_clock (
    .clk       (clk),
    .rst       (rst),
    .stamp     (stamp),
    .day_valid (day_valid),
    .day_ready (day_ready),
    .day_item  (day_item)
  );

  assign en5 = !v5 || date.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign day_ready = en1;

  assign days68_c  = day_item.tot_day + sctd_pkg::DaysTo1970;
  assign wsum_c    = day_item.tot_day + sctd_pkg::DayCntW'(sctd_pkg::WeekdayBase);
  assign wk_prod   = wsum_c * sctd_pkg::RecipWeek;
  assign quad_prod = days68_c * sctd_pkg::RecipQuad;

  assign in_quad_c  = days68_1[10:0] - sctd_pkg::InQuadW'(quads_1 * sctd_pkg::DaysPerQuad);
  assign past_feb_c = in_quad_c >= sctd_pkg::FebEndLeap;

  assign yr_prod = diff_2 * sctd_pkg::RecipYear;

  always_comb begin
    mon_c = sctd_pkg::MonW'(1);
    st_c  = '0;
    cand  = '0;
    for (int i = 0; i < sctd_pkg::NumMonths; i++) begin
      cand = sctd_pkg::MonthStart[i] + sctd_pkg::YdayW'((i >= 2) && leap_4);
      if (yday_4 >= cand) begin
        mon_c = sctd_pkg::MonW'(i + 1);
        st_c  = cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= day_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      days68_1  <= days68_c;
      wsum_lo_1 <= wsum_c[2:0];
      q7_lo_1   <= wk_prod[21:19];
      quads_1   <= quad_prod[32:27];
      tod_1     <= day_item;
    end
    if (en2) begin
      wday_2 <= wsum_lo_1 - 3'(q7_lo_1 * 3'(sctd_pkg::DaysPerWeek));
      diff_2 <= days68_1 - sctd_pkg::DayCntW'(quads_1)
                - sctd_pkg::DayCntW'(past_feb_c);
      inc_2  <= past_feb_c && (in_quad_c <= sctd_pkg::LeapYearEnd);
      tod_2  <= tod_1;
    end
    if (en3) begin
      yrs_3     <= yr_prod[32:25];
      diff_lo_3 <= diff_2[8:0];
      inc_3     <= inc_2;
      wday_3    <= wday_2;
      tod_3     <= tod_2;
    end
    if (en4) begin
      yday_4 <= diff_lo_3 - sctd_pkg::YdayW'(yrs_3 * sctd_pkg::YearDays)
                + sctd_pkg::YdayW'(inc_3);
      leap_4 <= yrs_3[1:0] == 2'b00;
      year_4 <= sctd_pkg::YearW'(yrs_3) + sctd_pkg::BaseYear;
      wday_4 <= wday_3;
      tod_4  <= tod_3;
    end
    if (en5) begin
      sec_5  <= tod_4.sec;
      min_5  <= tod_4.min;
      hour_5 <= tod_4.hour;
      mday_5 <= sctd_pkg::MdayW'(yday_4 - st_c + sctd_pkg::YdayW'(1));
      mon_5  <= mon_c;
      year_5 <= year_4;
      yday_5 <= yday_4;
      wday_5 <= wday_4;
    end
  end

  assign date.valid         = v5;
  assign date.sec_of_minute = sec_5;
  assign date.min_of_hour   = min_5;
  assign date.hour_of_day   = hour_5;
  assign date.day_of_month  = mday_5;
  assign date.month_number  = mon_5;
  assign date.full_year     = year_5;
  assign date.day_of_year   = yday_5;
  assign date.weekday       = wday_5;

  a_quad_rem: assert property (@(posedge clk) disable iff (rst)
    v1 |-> in_quad_c < sctd_pkg::DaysPerQuad)
    else $error("day within four-year block out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    v5 |-> (mon_5 != 4'd0) && (mon_5 <= 4'd12) && (mday_5 != 5'd0)
           && (wday_5 <= 3'd6) && (yday_5 <= 9'd365))
    else $error("calendar field out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    v5 && !date.ready |=> v5)
    else $error("output item dropped while stalled");

  a_year_leap: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (leap_4 == (year_4[1:0] == 2'b00)))
    else $error("leap flag disagrees with year");

endmodule

// ----- dv/calendar_date_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_checker
// Watches the stamp and date channels of the seconds-to-calendar-date unit.
// Every accepted timestamp is converted to the date it should produce. Each
// accepted date is compared field by field with the oldest pending
// conversion. Mismatches and unexpected dates add to the failure count.
// ----------------------------------------------------------------------------
module calendar_date_checker (
  input  logic clk,
  input  logic rst,
  sctd_in_if   stamp,
  sctd_out_if  date,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [sctd_pkg::SecW-1:0]  sec_of_minute;
    logic [sctd_pkg::SecW-1:0]  min_of_hour;
    logic [sctd_pkg::HourW-1:0] hour_of_day;
    logic [sctd_pkg::MdayW-1:0] day_of_month;
    logic [sctd_pkg::MonW-1:0]  month_number;
    logic [sctd_pkg::YearW-1:0] full_year;
    logic [sctd_pkg::YdayW-1:0] day_of_year;
    logic [sctd_pkg::WdayW-1:0] weekday;
  } calendar_date_t;

  calendar_date_t expected_dates[$];
  int             fails = 0;

  assign fail_count = fails;

  function automatic calendar_date_t epoch_to_date(
      input logic [sctd_pkg::EpochW-1:0] secs);
    logic [31:0]    tot_min, tot_hr, tot_day, days68, quads, in_quad;
    logic [31:0]    yrs, yday, yr, start, mday, wday;
    int             mon;
    logic           leap;
    calendar_date_t d;
    tot_min = secs / 32'(sctd_pkg::SecsPerMin);
    tot_hr  = tot_min / 32'(sctd_pkg::MinsPerHour);
    tot_day = tot_hr / 32'(sctd_pkg::HoursPerDay);
    d.sec_of_minute = sctd_pkg::SecW'(secs - tot_min * 32'(sctd_pkg::SecsPerMin));
    d.min_of_hour   = sctd_pkg::SecW'(tot_min - tot_hr * 32'(sctd_pkg::MinsPerHour));
    d.hour_of_day   = sctd_pkg::HourW'(tot_hr - tot_day * 32'(sctd_pkg::HoursPerDay));

    // rebase to 1968 so every four-year block opens with a leap year
    days68  = tot_day + 32'd731;
    quads   = days68 / 32'd1461;
    in_quad = days68 % 32'd1461;
    if (in_quad >= 32'd60) quads++;
    yrs  = (days68 - quads) / 32'd365;
    yday = days68 - yrs * 32'd365 - quads;
    if (in_quad <= 32'd365 && in_quad >= 32'd60) yday++;
    yr   = yrs + 32'd68;
    leap = (yr % 32'd4) == 32'd0;

    mon   = 12;
    start = 0;
    while (mon >= 1) begin
      start = 32'(sctd_pkg::MonthStart[mon-1]);
      if (mon > 2 && leap) start++;
      if (yday >= start) break;
      mon--;
    end
    if (mon == 0) begin
      mon   = 1;
      start = 0;
    end
    mday = yday - start + 32'd1;
    wday = (tot_day + 32'(sctd_pkg::WeekdayBase)) % 32'(sctd_pkg::DaysPerWeek);

    d.day_of_month = sctd_pkg::MdayW'(mday);
    d.month_number = sctd_pkg::MonW'(mon);
    d.full_year    = sctd_pkg::YearW'(yr + 32'd1900);
    d.day_of_year  = sctd_pkg::YdayW'(yday);
    d.weekday      = sctd_pkg::WdayW'(wday);
    return d;
  endfunction

  function automatic int check_field(input string name,
                                     input logic [sctd_pkg::YearW-1:0] want,
                                     input logic [sctd_pkg::YearW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    calendar_date_t want;
    int             errs;
    errs = 0;
    if (!rst) begin
      if (date.valid && date.ready) begin
        if (expected_dates.size() == 0) begin
          $error("date item arrived with no timestamp outstanding");
          errs++;
        end else begin
          want = expected_dates.pop_front();
          errs += check_field("sec_of_minute", sctd_pkg::YearW'(want.sec_of_minute),
                              sctd_pkg::YearW'(date.sec_of_minute));
          errs += check_field("min_of_hour", sctd_pkg::YearW'(want.min_of_hour),
                              sctd_pkg::YearW'(date.min_of_hour));
          errs += check_field("hour_of_day", sctd_pkg::YearW'(want.hour_of_day),
                              sctd_pkg::YearW'(date.hour_of_day));
          errs += check_field("day_of_month", sctd_pkg::YearW'(want.day_of_month),
                              sctd_pkg::YearW'(date.day_of_month));
          errs += check_field("month_number", sctd_pkg::YearW'(want.month_number),
                              sctd_pkg::YearW'(date.month_number));
          errs += check_field("full_year", want.full_year, date.full_year);
          errs += check_field("day_of_year", sctd_pkg::YearW'(want.day_of_year),
                              sctd_pkg::YearW'(date.day_of_year));
          errs += check_field("weekday", sctd_pkg::YearW'(want.weekday),
                              sctd_pkg::YearW'(date.weekday));
        end
      end
      if (stamp.valid && stamp.ready) begin
        expected_dates.push_back(epoch_to_date(stamp.epoch_seconds));
      end
    end
    fails   <= fails + errs;
    pending <= expected_dates.size();
  end

endmodule

// ----- dv/seconds_to_calendar_date_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_unit_tb
// Streams timestamps into the seconds-to-calendar-date unit: calendar edge
// cases first, then random stamps biased toward day, year and leap-day
// boundaries. Both channels idle at random, with a stretch of full flow and
// one pause until the pipeline empties. A checker module predicts and
// compares every date; this module gives the verdict.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date_unit_tb;

  localparam int NumRandom   = 1600;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 30;
  localparam int PauseAt     = 800;
  localparam int SteadyFrom  = 1000;
  localparam int SteadyTo    = 1300;

  localparam logic [sctd_pkg::EpochW-1:0] EdgeStamps [25] = '{
    32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd31535999, 32'd31536000, 32'd68169600, 32'd68255999, 32'd68256000,
    32'd94608000, 32'd94694399, 32'd951782400, 32'd2147483647, 32'd2147483648,
    32'd4107542399, 32'd4107542400, 32'd4134067199, 32'd4134067200,
    32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF
  };

  localparam int QuadOffsets [13] = '{
    -1, 0, 58, 59, 60, 61, 365, 366, 730, 731, 1095, 1096, 1460
  };

  logic clk;
  logic rst;
  logic steady_flow;
  int   cycle_count = 0;
  int   fail_count;
  int   pending;

  sctd_in_if  stamp_if ();
  sctd_out_if date_if ();

  seconds_to_calendar_date_unit dut (
    .clk   (clk),
    .rst   (rst),
    .stamp (stamp_if),
    .date  (date_if)
  );

  calendar_date_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .stamp      (stamp_if),
    .date       (date_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("seconds_to_calendar_date_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      date_if.ready <= 1'b0;
    end else if (steady_flow) begin
      date_if.ready <= 1'b1;
    end else begin
      date_if.ready <= $urandom_range(0, 99) >= 30;
    end
  end

  function automatic logic [sctd_pkg::EpochW-1:0] random_stamp();
    int          day;
    logic [31:0] tod;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: begin
        day = $urandom_range(0, 49710);
        tod = $urandom_range(0, 86399);
      end
      default: begin
        day = $urandom_range(1, 34) * 1461 - 731 + QuadOffsets[$urandom_range(0, 12)];
        if (day > 49710) day = 49710;
        case ($urandom_range(0, 2))
          0: tod = 0;
          1: tod = 86399;
          default: tod = $urandom_range(0, 86399);
        endcase
      end
    endcase
    return 32'(day) * 32'd86400 + tod;
  endfunction

  task automatic send_stamp(input logic [sctd_pkg::EpochW-1:0] secs);
    stamp_if.valid         <= 1'b1;
    stamp_if.epoch_seconds <= secs;
    do @(posedge clk); while (!stamp_if.ready);
    if (!steady_flow && $urandom_range(0, 99) < 30) begin
      stamp_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 30);
    end
  endtask

  initial begin
    clk                    = 1'b0;
    rst                    = 1'b1;
    steady_flow            = 1'b0;
    stamp_if.valid         = 1'b0;
    stamp_if.epoch_seconds = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (EdgeStamps[i]) send_stamp(EdgeStamps[i]);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == PauseAt) begin
        stamp_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      steady_flow <= n >= SteadyFrom && n < SteadyTo;
      send_stamp(random_stamp());
    end

    stamp_if.valid <= 1'b0;
    steady_flow    <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("seconds_to_calendar_date_unit test passed");
    end else begin
      $display("seconds_to_calendar_date_unit test failed");
    end
    $finish;
  end

endmodule
